// File: rtl/ptpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpm_pkg
// shared types, constants and helpers of the palette tint pixel map
// ----------------------------------------------------------------------------
package ptpm_pkg;

  localparam int PixW       = 24;
  localparam int ChW        = 8;
  localparam int NumCh      = 3;
  localparam int SatLimit   = 24;
  localparam int WarmMargin = 24;
  localparam int Knee       = 176;
  localparam int Full       = 255;
  localparam int UpperSpan  = 79;
  localparam int HalfWeight = 128;

  // register map
  typedef enum logic [1:0] {
    CFG_BACKGROUND = 2'd0,
    CFG_FOREGROUND = 2'd1,
    CFG_ACCENT     = 2'd2,
    CFG_WARM       = 2'd3
  } cfg_idx_e;

  // middle colour choice
  typedef enum logic [1:0] {
    MID_SOFT   = 2'd0,
    MID_WARM   = 2'd1,
    MID_ACCENT = 2'd2
  } mid_sel_e;

  typedef logic [ChW-1:0] weight_lut_t [256];

  // stage 1 -> stage 2
  typedef struct packed {
    logic [ChW-1:0] hi;
    mid_sel_e       sel;
  } s1_t;

  // stage 2 -> stage 3: blend endpoints and weight
  typedef struct packed {
    logic [PixW-1:0] a;
    logic [PixW-1:0] b;
    logic [ChW-1:0]  t;
  } s2_t;

  // stage 3 -> stage 4: partial products per channel
  typedef struct packed {
    logic [NumCh-1:0][2*ChW-1:0] pa;
    logic [NumCh-1:0][2*ChW-1:0] pb;
  } s3_t;

  // blend weight for every brightness, built at elaboration
  function automatic weight_lut_t build_weight_lut();
    weight_lut_t lut;
    int          w;
    for (int i = 0; i < 256; i++) begin
      if (i < Knee) begin
        w = i * Full / Knee;
      end else begin
        w = (i - Knee) * Full / UpperSpan;
      end
      lut[i] = ChW'(w);
    end
    return lut;
  endfunction

  localparam weight_lut_t WeightLut = build_weight_lut();

  // floor(x / 255) for x up to 255*255, by reciprocal shift-add
  function automatic logic [ChW-1:0] div255(logic [2*ChW-1:0] x);
    logic [2*ChW:0] tmp;
    tmp = {1'b0, x} + {{(ChW+1){1'b0}}, x[2*ChW-1:ChW]} + {{(2*ChW){1'b0}}, 1'b1};
    return tmp[2*ChW-1:ChW];
  endfunction

endpackage

// File: rtl/ptpm_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpm_classify
// stage 1: brightness, saturation and hue class of the incoming pixel
// ----------------------------------------------------------------------------
module ptpm_classify (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       en_i,
  input  logic [ptpm_pkg::PixW-1:0]  pixel_i,
  output logic                       valid_o,
  output ptpm_pkg::s1_t              data_o
);

  logic [ptpm_pkg::ChW-1:0] r, g, b;
  logic [ptpm_pkg::ChW-1:0] hi, lo, sat;
  logic [ptpm_pkg::ChW:0]   b_margin;
  logic                     warm;
  logic                     valid_q;
  ptpm_pkg::s1_t            data_d, data_q;

  assign r = pixel_i[2*ptpm_pkg::ChW +: ptpm_pkg::ChW];
  assign g = pixel_i[ptpm_pkg::ChW +: ptpm_pkg::ChW];
  assign b = pixel_i[0 +: ptpm_pkg::ChW];

  always_comb begin
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
  end

  assign sat      = hi - lo;
  assign b_margin = {1'b0, b} + (ptpm_pkg::ChW+1)'(ptpm_pkg::WarmMargin);
  assign warm     = ({1'b0, r} > b_margin) && (r >= g);

  always_comb begin
    data_d.hi = hi;
    if (sat < ptpm_pkg::ChW'(ptpm_pkg::SatLimit)) begin
      data_d.sel = ptpm_pkg::MID_SOFT;
    end else if (warm) begin
      data_d.sel = ptpm_pkg::MID_WARM;
    end else begin
      data_d.sel = ptpm_pkg::MID_ACCENT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/ptpm_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpm_weight
// stage 2: middle colour, blend endpoints and blend weight lookup
// ----------------------------------------------------------------------------
module ptpm_weight (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       en_i,
  input  ptpm_pkg::s1_t              data_i,
  input  logic [ptpm_pkg::PixW-1:0]  bg_i,
  input  logic [ptpm_pkg::PixW-1:0]  fg_i,
  input  logic [ptpm_pkg::PixW-1:0]  accent_i,
  input  logic [ptpm_pkg::PixW-1:0]  warm_i,
  output logic                       valid_o,
  output ptpm_pkg::s2_t              data_o
);

  localparam int ChW = ptpm_pkg::ChW;

  logic [ptpm_pkg::PixW-1:0] half_mix_d, half_mix_q;
  logic [ptpm_pkg::PixW-1:0] mid;
  logic                      valid_q;
  ptpm_pkg::s2_t             data_d, data_q;

  // half blend of accent toward foreground, per channel
  always_comb begin
    logic [2*ChW-1:0] acc;
    for (int c = 0; c < ptpm_pkg::NumCh; c++) begin
      acc = (2*ChW)'(accent_i[c*ChW +: ChW])
              * (2*ChW)'(ptpm_pkg::Full - ptpm_pkg::HalfWeight)
          + (2*ChW)'(fg_i[c*ChW +: ChW]) * (2*ChW)'(ptpm_pkg::HalfWeight);
      half_mix_d[c*ChW +: ChW] = ptpm_pkg::div255(acc);
    end
  end

  // follows the theme registers through one register, ready before any
  // word accepted after a theme write reaches this stage
  always_ff @(posedge clk_i) begin
    half_mix_q <= half_mix_d;
  end

  always_comb begin
    unique case (data_i.sel)
      ptpm_pkg::MID_SOFT:   mid = half_mix_q;
      ptpm_pkg::MID_WARM:   mid = warm_i;
      ptpm_pkg::MID_ACCENT: mid = accent_i;
      default:              mid = accent_i;
    endcase
  end

  always_comb begin
    data_d.t = ptpm_pkg::WeightLut[data_i.hi];
    if (data_i.hi < ChW'(ptpm_pkg::Knee)) begin
      data_d.a = bg_i;
      data_d.b = mid;
    end else begin
      data_d.a = mid;
      data_d.b = fg_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/ptpm_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpm_blend
// stages 3 and 4: per-channel products, then sum and divide by 255
// ----------------------------------------------------------------------------
module ptpm_blend (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic                       en3_i,
  input  logic                       en4_i,
  input  ptpm_pkg::s2_t              data_i,
  output logic                       valid3_o,
  output logic                       valid4_o,
  output logic [ptpm_pkg::PixW-1:0]  pixel_o
);

  localparam int ChW = ptpm_pkg::ChW;

  logic [ChW-1:0]            inv_t;
  ptpm_pkg::s3_t             prod_d, prod_q;
  logic [ptpm_pkg::PixW-1:0] pixel_d, pixel_q;
  logic                      valid3_q, valid4_q;

  assign inv_t = ChW'(ptpm_pkg::Full) - data_i.t;

  // stage 3 products
  always_comb begin
    for (int c = 0; c < ptpm_pkg::NumCh; c++) begin
      prod_d.pa[c] = (2*ChW)'(data_i.a[c*ChW +: ChW]) * (2*ChW)'(inv_t);
      prod_d.pb[c] = (2*ChW)'(data_i.b[c*ChW +: ChW]) * (2*ChW)'(data_i.t);
    end
  end

  // stage 4 sum never exceeds 255*255
  always_comb begin
    for (int c = 0; c < ptpm_pkg::NumCh; c++) begin
      pixel_d[c*ChW +: ChW] = ptpm_pkg::div255(prod_q.pa[c] + prod_q.pb[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      if (en3_i) valid3_q <= valid_i;
      if (en4_i) valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) prod_q  <= prod_d;
    if (en4_i) pixel_q <= pixel_d;
  end

  assign valid3_o = valid3_q;
  assign valid4_o = valid4_q;
  assign pixel_o  = pixel_q;

endmodule

// File: rtl/palette_tint_pixel_map_core.sv
`timescale 1ns / 1ps
// path: an accepted word passes four register stages, the first loading at
//   the edge that accepts it and the last driving the output
// throughput: one word per cycle; set by the four-stage pipeline, each stage
//   holds while the one after it is full and stalled
// reset: pipeline valid bits clear, theme colours return to background black,
//   foreground white, accent black, warm black; no clearing pass
// ----------------------------------------------------------------------------
// palette_tint_pixel_map_core
// remaps a 24-bit rgb pixel onto a four-colour theme palette
// ----------------------------------------------------------------------------
module palette_tint_pixel_map_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [ptpm_pkg::PixW-1:0]  cfg_data_i,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ptpm_pkg::PixW-1:0]  pixel_in_i,
  // output words
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ptpm_pkg::PixW-1:0]  pixel_out_o
);

  // theme colour registers
  logic [ptpm_pkg::PixW-1:0] bg_q, fg_q, accent_q, warm_q;

  // pipeline handshake
  logic          v1, v2, v3, v4;
  logic          en1, en2, en3, en4;
  ptpm_pkg::s1_t s1;
  ptpm_pkg::s2_t s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q     <= '0;
      fg_q     <= '1;
      accent_q <= '0;
      warm_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (ptpm_pkg::cfg_idx_e'(cfg_index_i))
        ptpm_pkg::CFG_BACKGROUND: bg_q     <= cfg_data_i;
        ptpm_pkg::CFG_FOREGROUND: fg_q     <= cfg_data_i;
        ptpm_pkg::CFG_ACCENT:     accent_q <= cfg_data_i;
        ptpm_pkg::CFG_WARM:       warm_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its contents move on; bubbles collapse
  assign en4 = !v4 || out_ready_i;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_ready_o = en1;

  // stage 1: max, min, hue class
  ptpm_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .en_i    (en1),
    .pixel_i (pixel_in_i),
    .valid_o (v1),
    .data_o  (s1)
  );

  // stage 2: middle colour, endpoints, weight table
  ptpm_weight u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v1),
    .en_i     (en2),
    .data_i   (s1),
    .bg_i     (bg_q),
    .fg_i     (fg_q),
    .accent_i (accent_q),
    .warm_i   (warm_q),
    .valid_o  (v2),
    .data_o   (s2)
  );

  // stages 3 and 4: multiply, then sum and divide; stage 4 is the output reg
  ptpm_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v2),
    .en3_i    (en3),
    .en4_i    (en4),
    .data_i   (s2),
    .valid3_o (v3),
    .valid4_o (v4),
    .pixel_o  (pixel_out_o)
  );

  assign out_valid_o = v4;

`ifndef NO_ASSERTIONS
  // input side only backs up once every stage holds a word
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1 && v2 && v3 && v4))
    else $error("input blocked while pipeline has a free stage");

  // an unstalled output never blocks the input
  a_ready_when_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input blocked although output is draining");

  // an accepted word passes through every stage to the output when the sink keeps up
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o)
    else $error("accepted word did not reach the output in time");
`endif

endmodule
